// ===== rtl/core/sha256sh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Round constants, initial hash values, sigma functions and the control
// bundles shared by the sequencer, the message schedule and the round unit.
// ----------------------------------------------------------------------------
package sha256sh_pkg;

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [31:0] IV_TABLE [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] K_TABLE [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Round unit control
   typedef struct packed {
      logic load;     // copy chaining value into working variables
      logic round;    // run one compression round
      logic update;   // fold working variables into chaining value
      logic reinit;   // return chaining value to initial hash
   } sha_ctrl_type;

   // Message schedule control
   typedef struct packed {
      logic push;     // shift in an assembled message word
      logic advance;  // shift in the next expanded schedule word
   } sched_ctrl_type;

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

// ===== rtl/core/sha256sh_schedule.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message schedule
// Sixteen-word sliding window: filled with message words, then expanded one
// schedule word per round.
// ----------------------------------------------------------------------------
module sha256sh_schedule (
   input  logic                        clock,
   input  sha256sh_pkg::sched_ctrl_type ctrl,
   input  logic [31:0]                 push_word,
   output logic [31:0]                 w_head
);
   import sha256sh_pkg::*;

   logic [31:0] win_ff [16];
   logic [31:0] next_w;

   // window entry i holds W[t+i]
   assign next_w = small_sigma1(win_ff[14]) + win_ff[9] + small_sigma0(win_ff[1]) + win_ff[0];
   assign w_head = win_ff[0];

   always_ff @(posedge clock) begin
      if (ctrl.push || ctrl.advance) begin
         for (int i = 0; i < 15; i++) begin
            win_ff[i] <= win_ff[i + 1];
         end
         win_ff[15] <= ctrl.push ? push_word : next_w;
      end
   end

endmodule

// ===== rtl/core/sha256sh_compress.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round per cycle while ctrl.round is set, on the working
// variables, plus the chaining value and its end-of-block update.
// ----------------------------------------------------------------------------
module sha256sh_compress (
   input  logic                       clock,
   input  logic                       reset,
   input  sha256sh_pkg::sha_ctrl_type ctrl,
   input  logic [31:0]                k_word,
   input  logic [31:0]                w_word,
   input  logic [2:0]                 word_sel,
   output logic [31:0]                digest_word
);
   import sha256sh_pkg::*;

   logic [31:0] chain_ff [8];
   logic [31:0] v_ff [8];
   logic [31:0] ch;
   logic [31:0] maj;
   logic [31:0] t1;
   logic [31:0] t2;

   assign ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1  = v_ff[7] + big_sigma1(v_ff[4]) + ch + k_word + w_word;
   assign t2  = big_sigma0(v_ff[0]) + maj;

   assign digest_word = chain_ff[word_sel];

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= IV_TABLE;
      end else if (ctrl.reinit) begin
         chain_ff <= IV_TABLE;
      end else if (ctrl.update) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= chain_ff[i] + v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         v_ff <= chain_ff;
      end else if (ctrl.round) begin
         v_ff[0] <= t1 + t2;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1];
         v_ff[3] <= v_ff[2];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[5] <= v_ff[4];
         v_ff[6] <= v_ff[5];
         v_ff[7] <= v_ff[6];
      end
   end

endmodule

// ===== rtl/core/sha256_stream_hasher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-stream SHA-256 with padding and digest output as eight words.
// ----------------------------------------------------------------------------
// Each request carries at most one message byte (req_tuser) and may end the
// message (req_tlast). Every 64th byte starts a block compression: 64 rounds
// through the single round unit, one per cycle, then an update step that
// folds the result into the chaining value; req_tready stays low throughout
// the compression. Ending a message writes the padding bytes (0x80, zeros,
// 64-bit big-endian bit length) one per cycle through the same byte path,
// runs one or two more compressions, then presents the digest as eight
// 32-bit words on the rsp_ channel, word 0 first, one per accepted response.
// After word 7 the hash returns to its initial value and req_tready rises
// again. The bit counter wraps modulo 2^64.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] has_byte
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // last_word
);
   import sha256sh_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PAD    = 3'd1;
   localparam logic [2:0] ST_ROUND  = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   localparam logic [5:0] POS_LAST  = 6'd63;
   localparam logic [5:0] LEN_POS   = 6'd56;
   localparam logic [5:0] RND_LAST  = 6'd63;
   localparam logic [2:0] WORD_LAST = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [5:0]  pos_ff, pos_in;          // byte position in the block
   logic [23:0] acc_ff, acc_in;          // partial big-endian word
   logic [63:0] bit_len_ff, bit_len_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic        end_pend_ff, end_pend_in;
   logic        pad_first_ff, pad_first_in;
   logic        len_here_ff, len_here_in; // length field goes in this block
   logic        in_pad_ff, in_pad_in;
   logic [2:0]  out_idx_ff, out_idx_in;

   logic        req_acc;
   logic        rsp_acc;
   logic        wr_en;
   logic [7:0]  wr_byte;
   logic [63:0] len_shift;
   logic [31:0] w_head;
   logic [31:0] digest_word;

   sha_ctrl_type   cctl;
   sched_ctrl_type sctl;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // length bytes go out most significant first at positions 56..63
   assign len_shift = bit_len_ff >> {~pos_ff[2:0], 3'b000};

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      bit_len_in   = bit_len_ff;
      rnd_in       = rnd_ff;
      end_pend_in  = end_pend_ff;
      pad_first_in = pad_first_ff;
      len_here_in  = len_here_ff;
      in_pad_in    = in_pad_ff;
      out_idx_in   = out_idx_ff;
      wr_en        = 1'b0;
      wr_byte      = 8'h00;
      cctl         = '0;
      sctl         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser) begin
                  wr_en      = 1'b1;
                  wr_byte    = req_tdata;
                  bit_len_in = bit_len_ff + 64'd8;
               end
               if (req_tuser && pos_ff == POS_LAST) begin
                  // block full: compress first, pad afterwards if ending
                  state_in    = ST_ROUND;
                  end_pend_in = req_tlast;
                  rnd_in      = '0;
                  cctl.load   = 1'b1;
               end else if (req_tlast) begin
                  state_in     = ST_PAD;
                  pad_first_in = 1'b1;
                  in_pad_in    = 1'b1;
               end
            end
         end
         ST_PAD: begin
            wr_en = 1'b1;
            if (pad_first_ff) begin
               wr_byte      = PAD_MARK;
               pad_first_in = 1'b0;
               len_here_in  = (pos_ff < LEN_POS);
            end else if (pos_ff >= LEN_POS && len_here_ff) begin
               wr_byte = len_shift[7:0];
            end
            if (pos_ff == POS_LAST) begin
               state_in  = ST_ROUND;
               rnd_in    = '0;
               cctl.load = 1'b1;
            end
         end
         ST_ROUND: begin
            cctl.round   = 1'b1;
            sctl.advance = 1'b1;
            rnd_in       = rnd_ff + 6'd1;
            if (rnd_ff == RND_LAST) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cctl.update = 1'b1;
            end_pend_in = 1'b0;
            if (in_pad_ff) begin
               if (len_here_ff) begin
                  state_in   = ST_EMIT;
                  bit_len_in = '0;
                  in_pad_in  = 1'b0;
                  out_idx_in = '0;
               end else begin
                  // marker spilled past the length field: one more block
                  state_in    = ST_PAD;
                  len_here_in = 1'b1;
               end
            end else if (end_pend_ff) begin
               state_in     = ST_PAD;
               pad_first_in = 1'b1;
               in_pad_in    = 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_acc) begin
               if (out_idx_ff == WORD_LAST) begin
                  cctl.reinit = 1'b1;
                  state_in    = ST_IDLE;
                  out_idx_in  = '0;
               end else begin
                  out_idx_in = out_idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // shared byte path: assemble big-endian words, push every fourth byte
      if (wr_en) begin
         pos_in = pos_ff + 6'd1;
         acc_in = {acc_ff[15:0], wr_byte};
         if (pos_ff[1:0] == 2'b11) begin
            sctl.push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         bit_len_ff   <= '0;
         rnd_ff       <= '0;
         end_pend_ff  <= 1'b0;
         pad_first_ff <= 1'b0;
         len_here_ff  <= 1'b0;
         in_pad_ff    <= 1'b0;
         out_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         bit_len_ff   <= bit_len_in;
         rnd_ff       <= rnd_in;
         end_pend_ff  <= end_pend_in;
         pad_first_ff <= pad_first_in;
         len_here_ff  <= len_here_in;
         in_pad_ff    <= in_pad_in;
         out_idx_ff   <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   sha256sh_schedule u_schedule (
      .clock     (clock),
      .ctrl      (sctl),
      .push_word ({acc_ff, wr_byte}),
      .w_head    (w_head)
   );

   sha256sh_compress u_compress (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (cctl),
      .k_word      (K_TABLE[rnd_ff]),
      .w_word      (w_head),
      .word_sel    (out_idx_ff),
      .digest_word (digest_word)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = digest_word;
   assign rsp_tuser  = out_idx_ff;
   assign rsp_tlast  = (out_idx_ff == WORD_LAST);

   // hold requests off while the digest is being delivered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted during digest output");

   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rnd_ff == RND_LAST) |=> (state_ff == ST_UPDATE))
      else $error("compression did not end after the last round");

   a_emit_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (pos_ff == 6'd0))
      else $error("digest output with a partly filled block");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_tlast) |=> (req_tready && bit_len_ff == 64'd0))
      else $error("hasher not restarted after the final digest word");

endmodule
